// ===== hdl/text_console_cursor_renderer_defines.svh =====
// assertion macros used by the console cursor sequencer
`ifndef TEXT_CONSOLE_CURSOR_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_RENDERER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define TCCR_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("tccr assertion failed");

// condition holds in the cycle after the trigger
`define TCCR_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("tccr assertion failed");

`endif

// ===== hdl/tccr_pkg.sv =====
package tccr_pkg;

    // field widths
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int CODE_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int ADDR_W    = 48;
    localparam int PITCH_W   = 20;
    localparam int CW_W      = 6;
    localparam int COLS_W    = 9;
    localparam int ROWS_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;

    // screen limits and tab stop (tab stop is a power of two)
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;
    localparam int TAB_STOP    = 8;
    localparam int MAX_RESULTS = 8;
    localparam int TAB_RAW_W   = $clog2(TAB_STOP + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // character codes
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] BLANK_GLYPH    = 8'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FB_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd4;

    // register reset values
    localparam logic [PITCH_W-1:0] PITCH_RESET = 20'd10240;
    localparam logic [CW_W-1:0]    CW_RESET    = 6'd8;
    localparam logic [COLS_W-1:0]  COLS_RESET  = 9'd80;
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 8'd25;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cursor_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic mult;
        logic add;
    } tccr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_newline;
        logic more;
    } tccr_status_t;

    // column past the end goes to the next row, row past the end to row 0
    function automatic cursor_t wrap_cursor(input logic [COLS_W-1:0] col_in,
                                            input logic [ROW_W-1:0] row_in,
                                            input logic [COLS_W-1:0] eff_cols,
                                            input logic [ROWS_W-1:0] eff_rows);
        logic [COLS_W-1:0] col_w;
        logic [ROWS_W-1:0] row_w;
        cursor_t           res;
        col_w = col_in;
        row_w = {1'b0, row_in};
        if (col_w >= eff_cols)
        begin
            row_w = row_w + 1'b1;
            col_w = '0;
        end
        if (row_w >= eff_rows)
        begin
            row_w = '0;
        end
        res.col = col_w[COL_W-1:0];
        res.row = row_w[ROW_W-1:0];
        return res;
    endfunction

endpackage

// ===== hdl/tccr_ctrl.sv =====
`include "text_console_cursor_renderer_defines.svh"

module tccr_ctrl
    import tccr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         out_ready,
    input  tccr_status_t status,
    output tccr_cmd_t    cmd,
    output logic         in_ready,
    output logic         out_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MULT,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    // commands follow the state
    assign cmd.load   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.decode = (state_reg == ST_DECODE);
    assign cmd.mult   = (state_reg == ST_MULT);
    assign cmd.add    = (state_reg == ST_ADD);

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    // sequencer: decode, then multiply / add / present per draw command; a newline returns to idle after decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_ready_reg <= 1'b0;
                        state_reg    <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    if (status.is_newline)
                    begin
                        in_ready_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MULT;
                    end
                end
                ST_MULT:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (status.more)
                        begin
                            state_reg <= ST_MULT;
                        end
                        else
                        begin
                            in_ready_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
            endcase
        end
    end

    // one side of the block open at a time
    `TCCR_ASSERT_SAME(a_no_overlap, clk, rst_n, in_ready_reg, !out_valid_reg)
    // an accepted request closes the input
    `TCCR_ASSERT_NEXT(a_accept_closes, clk, rst_n, in_valid && in_ready_reg, !in_ready_reg)
    // a computed address is presented next cycle
    `TCCR_ASSERT_NEXT(a_add_presents, clk, rst_n, cmd.add, out_valid_reg)
    // final command taken reopens the input
    `TCCR_ASSERT_NEXT(a_done_reopens, clk, rst_n,
                      out_valid_reg && out_ready && !status.more, in_ready_reg)

endmodule

// ===== hdl/tccr_datapath.sv =====
module tccr_datapath
    import tccr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [COLOR_W-1:0]   fg_color,
    input  logic [COLOR_W-1:0]   bg_color,
    input  tccr_cmd_t            cmd,
    output tccr_status_t         status,
    output logic [CODE_W-1:0]    glyph_code,
    output logic [COL_W-1:0]     cell_column,
    output logic [ROW_W-1:0]     cell_row,
    output logic [ADDR_W-1:0]    pixel_address,
    output logic [COLOR_W-1:0]   draw_fg,
    output logic [COLOR_W-1:0]   draw_bg,
    output logic                 last
);

    localparam int RP_W = ROW_W + PITCH_W;
    localparam int CP_W = COL_W + CW_W;
    localparam logic [TAB_RAW_W-1:0] TAB_MASK = TAB_RAW_W'(TAB_STOP - 1);

    logic [ADDR_W-1:0]  fb_base_reg;
    logic [PITCH_W-1:0] row_pitch_reg;
    logic [CW_W-1:0]    char_width_reg;
    logic [COLS_W-1:0]  columns_reg;
    logic [ROWS_W-1:0]  rows_reg;

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [CNT_W-1:0]   remaining_reg;

    logic [CODE_W-1:0]  char_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [RP_W-1:0]    rp_prod_reg;
    logic [CP_W-1:0]    cp_prod_reg;

    logic [CODE_W-1:0]  glyph_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] out_fg_reg;
    logic [COLOR_W-1:0] out_bg_reg;
    logic               last_reg;

    logic [COLS_W-1:0]    eff_cols;
    logic [ROWS_W-1:0]    eff_rows;
    logic                 is_newline;
    logic                 is_back;
    logic                 is_tab;
    logic [TAB_RAW_W-1:0] tab_raw;
    logic [CNT_W-1:0]     tab_count;
    logic [COLS_W-1:0]    adv_col;
    cursor_t              nl_cursor;
    cursor_t              adv_cursor;

    // clamp the screen size to what the cursor can address
    always_comb
    begin
        if (columns_reg == '0)
            eff_cols = COLS_W'(1);
        else if (columns_reg > COLS_W'(MAX_COLUMNS))
            eff_cols = COLS_W'(MAX_COLUMNS);
        else
            eff_cols = columns_reg;
        if (rows_reg == '0)
            eff_rows = ROWS_W'(1);
        else if (rows_reg > ROWS_W'(MAX_ROWS))
            eff_rows = ROWS_W'(MAX_ROWS);
        else
            eff_rows = rows_reg;
    end

    // character class
    assign is_newline = (char_reg == CODE_NEWLINE);
    assign is_back    = (char_reg == CODE_BACKSPACE);
    assign is_tab     = (char_reg == CODE_TAB);

    // blanks up to the next tab stop, capped at the result limit
    always_comb
    begin
        tab_raw = TAB_RAW_W'(TAB_STOP) - (TAB_RAW_W'(col_reg) & TAB_MASK);
        if (tab_raw > TAB_RAW_W'(MAX_RESULTS))
            tab_count = CNT_W'(MAX_RESULTS);
        else
            tab_count = CNT_W'(tab_raw);
    end

    // cursor moves
    assign nl_cursor  = wrap_cursor(eff_cols, row_reg, eff_cols, eff_rows);
    assign adv_col    = is_back ? {1'b0, col_reg} : ({1'b0, col_reg} + 1'b1);
    assign adv_cursor = wrap_cursor(adv_col, row_reg, eff_cols, eff_rows);

    assign status.is_newline = is_newline;
    assign status.more       = (remaining_reg != '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_base_reg    <= '0;
            row_pitch_reg  <= PITCH_RESET;
            char_width_reg <= CW_RESET;
            columns_reg    <= COLS_RESET;
            rows_reg       <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FB_BASE:    fb_base_reg    <= cfg_data[ADDR_W-1:0];
                REG_ROW_PITCH:  row_pitch_reg  <= cfg_data[PITCH_W-1:0];
                REG_CHAR_WIDTH: char_width_reg <= cfg_data[CW_W-1:0];
                REG_COLUMNS:    columns_reg    <= cfg_data[COLS_W-1:0];
                REG_ROWS:       rows_reg       <= cfg_data[ROWS_W-1:0];
                default:        ;
            endcase
        end
    end

    // cursor and draw count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            remaining_reg <= '0;
        end
        else if (cmd.decode)
        begin
            remaining_reg <= is_tab ? tab_count : CNT_W'(1);
            if (is_newline)
            begin
                col_reg <= nl_cursor.col;
                row_reg <= nl_cursor.row;
            end
            else if (is_back)
            begin
                // step back, wrapping to the last column and row
                if (col_reg == '0)
                begin
                    col_reg <= COL_W'(eff_cols - 1'b1);
                    if (row_reg == '0)
                        row_reg <= ROW_W'(eff_rows - 1'b1);
                    else
                        row_reg <= row_reg - 1'b1;
                end
                else
                begin
                    col_reg <= col_reg - 1'b1;
                end
            end
        end
        else if (cmd.add)
        begin
            col_reg       <= adv_cursor.col;
            row_reg       <= adv_cursor.row;
            remaining_reg <= remaining_reg - 1'b1;
        end
    end

    // request capture and address products
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= char_code;
            fg_reg   <= fg_color;
            bg_reg   <= bg_color;
        end
        if (cmd.mult)
        begin
            rp_prod_reg <= RP_W'(row_reg) * RP_W'(row_pitch_reg);
            cp_prod_reg <= CP_W'(col_reg) * CP_W'(char_width_reg);
        end
    end

    // draw command output register
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            glyph_reg   <= (is_back || is_tab) ? BLANK_GLYPH : char_reg;
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
            addr_reg    <= fb_base_reg + ADDR_W'(rp_prod_reg) + ADDR_W'(cp_prod_reg);
            out_fg_reg  <= fg_reg;
            out_bg_reg  <= bg_reg;
            last_reg    <= (remaining_reg == CNT_W'(1));
        end
    end

    assign glyph_code    = glyph_reg;
    assign cell_column   = out_col_reg;
    assign cell_row      = out_row_reg;
    assign pixel_address = addr_reg;
    assign draw_fg       = out_fg_reg;
    assign draw_bg       = out_bg_reg;
    assign last          = last_reg;

endmodule

// ===== hdl/text_console_cursor_renderer.sv =====
// a printable byte or backspace passes decode, multiply and add, then is drawn
// each further tab blank passes multiply and add again once the previous one is taken
// newline draws nothing and the input reopens after the decode state
// the sequencer takes one request at a time; the output state waits for out_ready
// reset: async, clears the cursor to 0,0 and loads the register defaults
module text_console_cursor_renderer
    import tccr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [COLOR_W-1:0]   fg_color,
    input  logic [COLOR_W-1:0]   bg_color,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CODE_W-1:0]    glyph_code,
    output logic [COL_W-1:0]     cell_column,
    output logic [ROW_W-1:0]     cell_row,
    output logic [ADDR_W-1:0]    pixel_address,
    output logic [COLOR_W-1:0]   draw_fg,
    output logic [COLOR_W-1:0]   draw_bg,
    output logic                 last
);

    tccr_cmd_t    cmd;
    tccr_status_t status;

    // sequencer
    tccr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    // cursor, registers and address arithmetic
    tccr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .char_code     (char_code),
        .fg_color      (fg_color),
        .bg_color      (bg_color),
        .cmd           (cmd),
        .status        (status),
        .glyph_code    (glyph_code),
        .cell_column   (cell_column),
        .cell_row      (cell_row),
        .pixel_address (pixel_address),
        .draw_fg       (draw_fg),
        .draw_bg       (draw_bg),
        .last          (last)
    );

endmodule
